### src/ttd_pkg.sv
// Shared constants, codes and a helper function of the tag tree decoder.
package ttd_pkg;

  localparam int unsigned MAX_GRID_SIDE = 32;
  localparam int unsigned VALUE_BITS    = 16;

  localparam int unsigned SIDE_BITS  = 6;
  localparam int unsigned IDX_BITS   = 10;
  localparam int unsigned LAYER_BITS = 16;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam int unsigned LEVELS     = $clog2(MAX_GRID_SIDE) + 1;
  localparam int unsigned LVL_BITS   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned BLD_BITS   = $clog2(LEVELS + 1);
  localparam int unsigned COORD_BITS = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;
  localparam int unsigned DIV_BITS   = IDX_BITS + 1;
  localparam int unsigned CNT_BITS   = $clog2(IDX_BITS);

  // Total node count of the largest tree, summed over all levels.
  function automatic int unsigned node_total(input int unsigned side, input int unsigned lv);
    int unsigned s;
    int unsigned sum;
    s = side;
    sum = 0;
    for (int unsigned l = 0; l < lv; l++) begin
      sum = sum + s * s;
      s = (s + 1) / 2;
    end
    return sum;
  endfunction

  localparam int unsigned NODE_COUNT = node_total(MAX_GRID_SIDE, LEVELS);
  localparam int unsigned ADDR_BITS  = $clog2(NODE_COUNT);
  localparam int unsigned WORD_BITS  = VALUE_BITS + 1;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  localparam logic [1:0] KIND_INCL  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_BIT   = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_W = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_H = 2'd1;

endpackage

### src/tag_tree_decoder.sv
// Quad tag tree decoder with node storage in a single-port-write synchronous memory.
//
// Usage: items enter on the in channel (in_valid_i, in_stall_o) and each one yields
// exactly one result on the out channel (out_valid_o, out_stall_i). A clear item or an
// out-of-turn item has its result ready for transfer in the cycle after its own transfer.
// A query first maps its leaf index onto grid coordinates with a shared bit-serial
// divider (a pass taking the index modulo the grid size, then a pass dividing by
// the width), then walks root to leaf; every level passes four steps (address,
// memory read, load, evaluate with write-back). While a walk waits for a header
// bit, only header bits advance it. Grid size is set through the cfg channel
// (index 0 width, index 1 height), which is always ready. Reset, a write to the
// width or height register and a clear item start a clearing pass over all
// NODE_COUNT node words (1365) that zeroes the node memory and rebuilds the level
// table; no item is taken during that pass. A finished result is held in an output
// register; when the receiver stalls, the result stays there and no new item is
// taken until that register drains.
module tag_tree_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          kind_i,
  input  logic [ttd_pkg::IDX_BITS-1:0]        leaf_index_i,
  input  logic [ttd_pkg::LAYER_BITS-1:0]      layer_i,
  input  logic                                header_bit_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                need_bit_o,
  output logic                                done_res_o,
  output logic                                included_o,
  output logic [ttd_pkg::VALUE_BITS-1:0]      leaf_value_o,
  output logic                                status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ttd_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [ttd_pkg::SIDE_BITS-1:0]       cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_ADDR  = 4'd4;
  localparam logic [3:0] S_READ  = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_EVAL  = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd8;

  localparam int unsigned VB = ttd_pkg::VALUE_BITS;
  localparam int unsigned AB = ttd_pkg::ADDR_BITS;
  localparam int unsigned SB = ttd_pkg::SIDE_BITS;
  localparam int unsigned CB = ttd_pkg::COORD_BITS;
  localparam int unsigned LB = ttd_pkg::LVL_BITS;
  localparam int unsigned DB = ttd_pkg::DIV_BITS;
  localparam int unsigned IB = ttd_pkg::IDX_BITS;

  logic [3:0]        state_q, state_d;
  logic [SB-1:0]     cfg_w_q, cfg_w_d, cfg_h_q, cfg_h_d;
  logic [DB-1:0]     n_q;
  logic [SB-1:0]     bw_q, bw_d, bh_q, bh_d;
  logic [AB-1:0]     bacc_q, bacc_d;
  logic [ttd_pkg::BLD_BITS-1:0] blvl_q, blvl_d;
  logic [LB-1:0]     top_q, top_d;
  logic [AB-1:0]     off_q [ttd_pkg::LEVELS];
  logic [SB-1:0]     wl_q  [ttd_pkg::LEVELS];
  logic [AB-1:0]     swp_q, swp_d;
  logic [DB-1:0]     rem_q, rem_d, divisor_q, divisor_d;
  logic [IB-1:0]     quo_q, quo_d;
  logic [ttd_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic [CB-1:0]     x_q, x_d, y_q, y_d;
  logic [LB-1:0]     lvl_q, lvl_d;
  logic [VB-1:0]     lb_q, lb_d, thr_q, thr_d;
  logic              full_q, full_d;
  logic [AB-1:0]     addr_q, addr_d;
  logic [VB-1:0]     cur_val_q, cur_val_d;
  logic              cur_known_q, cur_known_d;
  logic [ttd_pkg::WORD_BITS-1:0] rdata_q;
  logic [ttd_pkg::WORD_BITS-1:0] mem [ttd_pkg::NODE_COUNT];

  logic              out_valid_q, out_valid_d;
  logic              o_need_q, o_need_d, o_done_q, o_done_d, o_incl_q, o_incl_d;
  logic              o_stat_q, o_stat_d;
  logic [VB-1:0]     o_val_q, o_val_d;

  logic              can_take, in_acc, cfg_acc, produce, clr_start, bld_on;
  logic [SB-1:0]     cfg_clamped;
  logic [DB-1:0]     t_div, rem_n;
  logic [IB-1:0]     quo_n;
  logic              ge;
  logic [CB-1:0]     xl, yl;
  logic [CB+SB-1:0]  prod;
  logic [VB-1:0]     v_eval;
  logic              mem_we;
  logic [AB-1:0]     mem_wa;
  logic [ttd_pkg::WORD_BITS-1:0] mem_wd;

  assign can_take    = ((state_q == S_IDLE) || (state_q == S_WAIT)) &&
                       (!out_valid_q || !out_stall_i);
  assign in_stall_o  = !can_take;
  assign in_acc      = in_valid_i && can_take;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;

  assign out_valid_o  = out_valid_q;
  assign need_bit_o   = o_need_q;
  assign done_res_o   = o_done_q;
  assign included_o   = o_incl_q;
  assign leaf_value_o = o_val_q;
  assign status_o     = o_stat_q;

  always_comb begin
    cfg_clamped = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_clamped = SB'(1);
    end else if (cfg_data_i > SB'(ttd_pkg::MAX_GRID_SIDE)) begin
      cfg_clamped = SB'(ttd_pkg::MAX_GRID_SIDE);
    end
  end

  // One restoring division step per cycle.
  assign t_div = {rem_q[DB-2:0], quo_q[IB-1]};
  assign ge    = (t_div >= divisor_q);
  assign rem_n = ge ? (t_div - divisor_q) : t_div;
  assign quo_n = {quo_q[IB-2:0], ge};

  assign xl   = x_q >> lvl_q;
  assign yl   = y_q >> lvl_q;
  assign prod = yl * wl_q[lvl_q];

  assign v_eval = (!cur_known_q && (cur_val_q < lb_q)) ? lb_q : cur_val_q;
  assign bld_on = (state_q == S_CLEAR) && (blvl_q < ttd_pkg::BLD_BITS'(ttd_pkg::LEVELS));

  always_comb begin
    state_d     = state_q;
    cfg_w_d     = cfg_w_q;
    cfg_h_d     = cfg_h_q;
    bw_d        = bw_q;
    bh_d        = bh_q;
    bacc_d      = bacc_q;
    blvl_d      = blvl_q;
    top_d       = top_q;
    swp_d       = swp_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    divisor_d   = divisor_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    lvl_d       = lvl_q;
    lb_d        = lb_q;
    thr_d       = thr_q;
    full_d      = full_q;
    addr_d      = addr_q;
    cur_val_d   = cur_val_q;
    cur_known_d = cur_known_q;
    produce     = 1'b0;
    clr_start   = 1'b0;
    o_need_d    = o_need_q;
    o_done_d    = o_done_q;
    o_incl_d    = o_incl_q;
    o_val_d     = o_val_q;
    o_stat_d    = o_stat_q;
    mem_we      = 1'b0;
    mem_wa      = swp_q;
    mem_wd      = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (bld_on) begin
          if (((bw_q > SB'(1)) || (bh_q > SB'(1))) &&
              (blvl_q < ttd_pkg::BLD_BITS'(ttd_pkg::LEVELS - 1))) begin
            top_d = LB'(blvl_q + 1'b1);
          end
          bacc_d = bacc_q + AB'(bw_q) * AB'(bh_q);
          bw_d   = (bw_q >> 1) + SB'(bw_q[0]);
          bh_d   = (bh_q >> 1) + SB'(bh_q[0]);
          blvl_d = blvl_q + 1'b1;
        end
        if (swp_q == AB'(ttd_pkg::NODE_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          swp_d = swp_q + 1'b1;
        end
      end
      S_MOD: begin
        rem_d = rem_n;
        quo_d = quo_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ttd_pkg::CNT_BITS'(IB - 1)) begin
          quo_d     = rem_n[IB-1:0];
          rem_d     = '0;
          divisor_d = DB'(cfg_w_q);
          cnt_d     = '0;
          state_d   = S_DIVW;
        end
      end
      S_DIVW: begin
        rem_d = rem_n;
        quo_d = quo_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ttd_pkg::CNT_BITS'(IB - 1)) begin
          x_d     = rem_n[CB-1:0];
          y_d     = quo_n[CB-1:0];
          lvl_d   = top_q;
          lb_d    = '0;
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        addr_d  = off_q[lvl_q] + AB'(prod) + AB'(xl);
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        cur_val_d   = rdata_q[VB-1:0];
        cur_known_d = rdata_q[VB];
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        mem_we    = 1'b1;
        mem_wa    = addr_q;
        mem_wd    = {cur_known_q, v_eval};
        cur_val_d = v_eval;
        if (!cur_known_q && (full_q || (v_eval <= thr_q))) begin
          produce  = 1'b1;
          o_need_d = 1'b1;
          o_done_d = 1'b0;
          o_incl_d = 1'b0;
          o_val_d  = '0;
          o_stat_d = 1'b0;
          state_d  = S_WAIT;
        end else begin
          lb_d = v_eval;
          if (lvl_q == '0) begin
            produce  = 1'b1;
            o_need_d = 1'b0;
            o_done_d = 1'b1;
            o_incl_d = cur_known_q && (v_eval <= thr_q);
            o_val_d  = v_eval;
            o_stat_d = 1'b0;
            state_d  = S_IDLE;
          end else begin
            lvl_d   = lvl_q - 1'b1;
            state_d = S_ADDR;
          end
        end
      end
      S_IDLE, S_WAIT: begin
        if (in_acc) begin
          priority if (kind_i == ttd_pkg::KIND_CLEAR) begin
            produce   = 1'b1;
            clr_start = 1'b1;
            o_need_d  = 1'b0;
            o_done_d  = 1'b0;
            o_incl_d  = 1'b0;
            o_val_d   = '0;
            o_stat_d  = 1'b0;
          end else if (kind_i == ttd_pkg::KIND_BIT) begin
            if (state_q == S_IDLE) begin
              produce  = 1'b1;
              o_need_d = 1'b0;
              o_done_d = 1'b0;
              o_incl_d = 1'b0;
              o_val_d  = '0;
              o_stat_d = 1'b1;
            end else begin
              if (header_bit_i) begin
                cur_known_d = 1'b1;
              end else if (cur_val_q != ttd_pkg::VALUE_MAX) begin
                cur_val_d = cur_val_q + 1'b1;
              end
              state_d = S_EVAL;
            end
          end else if (state_q == S_WAIT) begin
            produce  = 1'b1;
            o_need_d = 1'b1;
            o_done_d = 1'b0;
            o_incl_d = 1'b0;
            o_val_d  = '0;
            o_stat_d = 1'b1;
          end else begin
            quo_d     = leaf_index_i;
            rem_d     = '0;
            divisor_d = n_q;
            cnt_d     = '0;
            thr_d     = layer_i;
            full_d    = (kind_i == ttd_pkg::KIND_VALUE);
            state_d   = S_MOD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      if (cfg_index_i == ttd_pkg::REG_GRID_W) begin
        cfg_w_d   = cfg_clamped;
        clr_start = 1'b1;
      end else if (cfg_index_i == ttd_pkg::REG_GRID_H) begin
        cfg_h_d   = cfg_clamped;
        clr_start = 1'b1;
      end
    end

    if (clr_start) begin
      state_d = S_CLEAR;
      swp_d   = '0;
      bw_d    = cfg_w_d;
      bh_d    = cfg_h_d;
      bacc_d  = '0;
      blvl_d  = '0;
      top_d   = '0;
    end

    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cfg_w_q     <= SB'(1);
      cfg_h_q     <= SB'(1);
      bw_q        <= SB'(1);
      bh_q        <= SB'(1);
      bacc_q      <= '0;
      blvl_q      <= '0;
      top_q       <= '0;
      swp_q       <= '0;
      cnt_q       <= '0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cfg_w_q     <= cfg_w_d;
      cfg_h_q     <= cfg_h_d;
      bw_q        <= bw_d;
      bh_q        <= bh_d;
      bacc_q      <= bacc_d;
      blvl_q      <= blvl_d;
      top_q       <= top_d;
      swp_q       <= swp_d;
      cnt_q       <= cnt_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= DB'(cfg_w_q) * DB'(cfg_h_q);
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    divisor_q   <= divisor_d;
    x_q         <= x_d;
    y_q         <= y_d;
    lb_q        <= lb_d;
    thr_q       <= thr_d;
    full_q      <= full_d;
    addr_q      <= addr_d;
    cur_val_q   <= cur_val_d;
    cur_known_q <= cur_known_d;
    o_need_q    <= o_need_d;
    o_done_q    <= o_done_d;
    o_incl_q    <= o_incl_d;
    o_val_q     <= o_val_d;
    o_stat_q    <= o_stat_d;
    if (bld_on) begin
      off_q[blvl_q[LB-1:0]] <= bacc_q;
      wl_q[blvl_q[LB-1:0]]  <= bw_q;
    end
  end

  // Node memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[addr_q];
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |-> (!out_valid_q || !out_stall_i))
    else $error("result produced while output register still held a pending result");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (addr_q < AB'(ttd_pkg::NODE_COUNT)))
    else $error("node address beyond the node memory");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDR) |-> (lvl_q <= top_q))
    else $error("walk level above the root level");

  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(o_done_q && o_need_q))
    else $error("result both finished and waiting for a bit");

  a_wait_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> !cur_known_q)
    else $error("walk waits at a node that is already known");

endmodule
